>>> hdl/bba_pkg.sv
package bba_pkg;

  localparam int NUM_BLOCKS_DEF      = 1024;
  localparam int RESERVED_BLOCKS_DEF = 4;
  localparam int BLOCK_FIELD_W       = 10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_WB,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } map_ctl_t;

  // lowest set bit of a byte
  function automatic logic [2:0] first_set(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> hdl/bba_map_ram.sv
module bba_map_ram
  import bba_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  map_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/block_bitmap_allocator_core.sv
// channel   ports                                            handshake
// command   in_command, in_block_index                       start & !busy
// result    out_status, out_allocated_block, out_any_free    out_valid, one cycle
//
// free: busy while the byte is read and written back; an index out of range answers at once.
// allocate: busy while the map bytes are scanned one by one, starting at the lowest
//   byte that may hold a free block; a full map answers at once.
// after reset the map is cleared one byte a cycle, busy high.
// the receiver cannot stall: each result is shown for exactly one cycle.
module block_bitmap_allocator_core
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [BLOCK_FIELD_W-1:0] in_block_index,
  output logic                     out_valid,
  output logic                     out_status,
  output logic [BLOCK_FIELD_W-1:0] out_allocated_block,
  output logic                     out_any_free
);

  localparam int MAP_BYTES = (NUM_BLOCKS + 7) / 8;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BW        = AW + 3;
  localparam int CW        = $clog2(NUM_BLOCKS + 1);
  localparam int TAIL      = NUM_BLOCKS % 8;
  localparam logic [7:0] LAST_MASK = (TAIL == 0) ? 8'hFF : 8'((9'd1 << TAIL) - 9'd1);
  localparam logic [7:0] RES_MASK  = 8'((9'd1 << RESERVED_BLOCKS) - 9'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [AW-1:0] hint_r, hint_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [BLOCK_FIELD_W-1:0] out_blk_r, out_blk_nxt;
  logic          out_free_r, out_free_nxt;

  map_ctl_t      ram_ctl;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [BW+BLOCK_FIELD_W-1:0] idx_ext;
  logic                        idx_ok;
  logic [7:0]                  avail;
  logic [2:0]                  pos;
  logic [7:0]                  set_byte;
  logic [BW+BLOCK_FIELD_W-1:0] blk_ext;
  logic [7:0]                  bit_mask;

  bba_map_ram #(
    .DEPTH(MAP_BYTES),
    .AW   (AW)
  ) u_map (
    .clk  (clk),
    .ctl  (ram_ctl),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign idx_ext  = {{BW{1'b0}}, in_block_index};
  assign idx_ok   = 32'(in_block_index) < 32'(NUM_BLOCKS);
  assign avail    = ~ram_rdata & ((addr_r == LAST_ADDR) ? LAST_MASK : 8'hFF);
  assign pos      = first_set(avail);
  assign set_byte = ram_rdata | (8'd1 << pos);
  assign blk_ext  = {{BLOCK_FIELD_W{1'b0}}, addr_r, pos};
  assign bit_mask = 8'd1 << bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hint_r      <= '0;
      cnt_r       <= CW'(NUM_BLOCKS - RESERVED_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r       <= addr_nxt;
    bit_r        <= bit_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    addr_nxt       = addr_r;
    bit_nxt        = bit_r;
    hint_nxt       = hint_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_free_nxt   = out_free_r;
    ram_ctl        = '0;
    ram_addr       = addr_r;
    ram_wdata      = ram_rdata;
    busy           = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        ram_ctl.we = 1'b1;
        ram_addr   = clr_r;
        ram_wdata  = (clr_r == '0) ? RES_MASK : 8'h00;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_command == CMD_FREE) begin
            if (idx_ok) begin
              addr_nxt   = idx_ext[AW+2:3];
              bit_nxt    = in_block_index[2:0];
              ram_ctl.re = 1'b1;
              ram_addr   = idx_ext[AW+2:3];
              state_nxt  = ST_FREE_WB;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_OK;
              out_blk_nxt    = '0;
              out_free_nxt   = cnt_r != '0;
            end
          end else if (cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_FULL;
            out_blk_nxt    = '0;
            out_free_nxt   = 1'b0;
          end else begin
            addr_nxt   = hint_r;
            ram_ctl.re = 1'b1;
            ram_addr   = hint_r;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_FREE_WB: begin
        ram_ctl.we = 1'b1;
        ram_wdata  = ram_rdata & ~bit_mask;
        if ((ram_rdata & bit_mask) != 8'h00) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if ((addr_r < hint_r) || (cnt_r == '0)) begin
          hint_nxt = addr_r;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_OK;
        out_blk_nxt    = '0;
        out_free_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_SCAN: begin
        if (avail != 8'h00) begin
          ram_ctl.we = 1'b1;
          ram_wdata  = set_byte;
          cnt_nxt    = cnt_r - CW'(1);
          if ((set_byte | ~((addr_r == LAST_ADDR) ? LAST_MASK : 8'hFF)) == 8'hFF) begin
            hint_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
          end else begin
            hint_nxt = addr_r;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_blk_nxt    = blk_ext[BLOCK_FIELD_W-1:0];
          out_free_nxt   = cnt_r != CW'(1);
          state_nxt      = ST_IDLE;
        end else begin
          addr_nxt   = (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
          ram_ctl.re = 1'b1;
          ram_addr   = addr_nxt;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_blk_r;
  assign out_any_free        = out_free_r;

endmodule
